>>> sv/sel_pkg.sv
package sel_pkg;

  localparam int unsigned MAX_LOCATIONS = 4096;
  localparam int unsigned MAX_ELEMENTS  = 16;
  localparam int unsigned VALUE_SLOTS   = 16384;
  localparam int unsigned VALUE_WIDTH   = 32;

  localparam int unsigned MASK_WORDS = (MAX_LOCATIONS + 63) / 64;
  localparam int unsigned WORD_W     = $clog2(MASK_WORDS);
  localparam int unsigned LOC_W      = $clog2(MAX_LOCATIONS);
  localparam int unsigned CNT_W      = $clog2(MAX_LOCATIONS + 1);
  localparam int unsigned ELEM_W     = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned Q_W        = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int unsigned QC_W       = (Q_W > 1) ? $clog2(Q_W) : 1;
  localparam int unsigned Z_W        = $clog2(MAX_LOCATIONS * MAX_ELEMENTS);
  localparam int unsigned DV_W       = CNT_W + Q_W;
  localparam int unsigned TOT_W      = CNT_W + ELEM_W;
  localparam int unsigned DCMP_W     = (TOT_W > 17) ? TOT_W : 17;
  localparam int unsigned PROD_W     = LOC_W + ELEM_W;
  localparam int unsigned SLOT_W     = $clog2(VALUE_SLOTS);

  typedef enum logic [1:0] {
    ACT_MASK  = 2'd0,
    ACT_VALUE = 2'd1,
    ACT_QUERY = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  typedef enum logic {
    CFG_LOC_COUNT  = 1'b0,
    CFG_ELEM_COUNT = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic              we;
    logic [WORD_W-1:0] waddr;
    logic [63:0]       wdata;
    logic [WORD_W-1:0] raddr;
  } mask_req_t;

  function automatic logic [6:0] popcount64(input logic [63:0] w);
    logic [6:0] n;
    n = '0;
    for (int i = 0; i < 64; i++) begin
      n = n + 7'(w[i]);
    end
    return n;
  endfunction

endpackage

>>> sv/sel_mask_store.sv
module sel_mask_store (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sel_pkg::mask_req_t req_i,
  output logic [63:0]        rdata_o
);
  import sel_pkg::*;

  logic [63:0]           mem [MASK_WORDS];
  logic [MASK_WORDS-1:0] vld_q;
  logic [63:0]           rd_q;
  logic                  rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rd_q <= mem[req_i.raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.we) begin
        vld_q[req_i.waddr] <= 1'b1;
      end
      rd_vld_q <= vld_q[req_i.raddr];
    end
  end

  assign rdata_o = rd_vld_q ? rd_q : '0;

endmodule

>>> sv/sparse_element_lookup.sv
// channel | direction | handshake               | payload
// --------+-----------+-------------------------+------------------------------------------
// in      | input     | in_valid_i / in_ready_o | action, word_index, mask_word,
//         |           |                         | value_slot, packed_value, dense_index
// out     | output    | out_valid_o/out_ready_i | value, status
// cfg     | input     | cfg_we_i (no wait)      | cfg_idx_i, cfg_data_i
//
// Mask and value writes are stored on acceptance. A query runs one check, four
// divide steps, a mask store read per word up to the word holding the location
// (0..63) for the rank, a slot multiply and a value read. Reset clears the mask
// occupancy flags and sets the config registers to defaults; the value store is
// not cleared. A stalled result holds the sequencer in its final step.
module sparse_element_lookup (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic                            cfg_idx_i,
  input  logic [12:0]                     cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [1:0]                      action_i,
  input  logic [5:0]                      word_index_i,
  input  logic [63:0]                     mask_word_i,
  input  logic [13:0]                     value_slot_i,
  input  logic signed [31:0]              packed_value_i,
  input  logic [16:0]                     dense_index_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [31:0]              value_o,
  output logic                            status_o
);
  import sel_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_CHK   = 8'b0000_0010,
    ST_DIV   = 8'b0000_0100,
    ST_RANK  = 8'b0000_1000,
    ST_RLAST = 8'b0001_0000,
    ST_MUL   = 8'b0010_0000,
    ST_RD    = 8'b0100_0000,
    ST_DONE  = 8'b1000_0000
  } state_e;

  state_e              state_q, state_d;
  logic [12:0]         loc_cnt_q;
  logic [4:0]          elem_cnt_q;
  logic [16:0]         d_q, d_d;
  logic [Z_W-1:0]      rem_q, rem_d;
  logic [Q_W-1:0]      el_q, el_d;
  logic [QC_W-1:0]     qc_q, qc_d;
  logic [WORD_W-1:0]   wcnt_q, wcnt_d;
  logic                acc_en_q;
  logic [LOC_W-1:0]    rank_q, rank_d;
  logic                hit_q, hit_d;
  logic [PROD_W-1:0]   slot_q, slot_d;
  logic                use_q, use_d;
  logic                oor_q, oor_d;
  logic [31:0]         val_rd_q;
  logic [31:0]         val_mem [VALUE_SLOTS];
  logic                out_valid_q;
  logic [31:0]         out_value_q;
  logic                out_status_q;

  logic                in_acc;
  logic                out_load;
  action_e             act;
  logic [CNT_W-1:0]    locs;
  logic [ELEM_W-1:0]   elems;
  logic [TOT_W-1:0]    total;
  logic [DV_W-1:0]     dvs;
  logic [LOC_W-1:0]    loc;
  logic [WORD_W-1:0]   loc_word;
  logic [5:0]          loc_bit;
  logic [63:0]         mask_rdata;
  logic [63:0]         low_mask;
  mask_req_t           mask_req;

  assign act        = action_e'(action_i);
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  assign locs  = (32'(loc_cnt_q) > MAX_LOCATIONS) ? CNT_W'(MAX_LOCATIONS) : CNT_W'(loc_cnt_q);
  assign elems = (32'(elem_cnt_q) > MAX_ELEMENTS) ? ELEM_W'(MAX_ELEMENTS) : ELEM_W'(elem_cnt_q);
  assign total = TOT_W'(locs) * TOT_W'(elems);
  assign dvs   = DV_W'(locs) << qc_q;

  assign loc      = rem_q[LOC_W-1:0];
  assign loc_word = WORD_W'(loc >> 6);
  assign loc_bit  = loc[5:0];
  assign low_mask = (64'd1 << loc_bit) - 64'd1;

  always_comb begin
    mask_req.we    = in_acc && (act == ACT_MASK) && (32'(word_index_i) < MASK_WORDS);
    mask_req.waddr = WORD_W'(word_index_i);
    mask_req.wdata = mask_word_i;
    mask_req.raddr = wcnt_q;
  end

  sel_mask_store u_mask (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mask_req),
    .rdata_o (mask_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loc_cnt_q  <= 13'(MAX_LOCATIONS);
      elem_cnt_q <= 5'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_LOC_COUNT:  loc_cnt_q  <= cfg_data_i;
        CFG_ELEM_COUNT: elem_cnt_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    d_d     = d_q;
    rem_d   = rem_q;
    el_d    = el_q;
    qc_d    = qc_q;
    wcnt_d  = wcnt_q;
    rank_d  = rank_q;
    hit_d   = hit_q;
    slot_d  = slot_q;
    use_d   = use_q;
    oor_d   = oor_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && act == ACT_QUERY) begin
          d_d     = dense_index_i;
          state_d = ST_CHK;
        end
      end
      ST_CHK: begin
        if (d_q == '0 || DCMP_W'(d_q) > DCMP_W'(total)) begin
          oor_d   = 1'b1;
          state_d = ST_DONE;
        end else begin
          oor_d   = 1'b0;
          rem_d   = Z_W'(d_q - 17'd1);
          el_d    = '0;
          qc_d    = QC_W'(Q_W - 1);
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (DV_W'(rem_q) >= dvs) begin
          rem_d       = Z_W'(DV_W'(rem_q) - dvs);
          el_d[qc_q]  = 1'b1;
        end
        if (qc_q == '0) begin
          wcnt_d  = '0;
          rank_d  = '0;
          state_d = ST_RANK;
        end else begin
          qc_d = qc_q - QC_W'(1);
        end
      end
      ST_RANK: begin
        if (acc_en_q) begin
          rank_d = rank_q + LOC_W'(popcount64(mask_rdata));
        end
        if (wcnt_q == loc_word) begin
          state_d = ST_RLAST;
        end else begin
          wcnt_d = wcnt_q + WORD_W'(1);
        end
      end
      ST_RLAST: begin
        rank_d  = rank_q + LOC_W'(popcount64(mask_rdata & low_mask));
        hit_d   = mask_rdata[loc_bit];
        state_d = ST_MUL;
      end
      ST_MUL: begin
        slot_d  = PROD_W'(rank_q) * PROD_W'(elems) + PROD_W'(el_q);
        state_d = ST_RD;
      end
      ST_RD: begin
        use_d   = hit_q && (32'(slot_q) < VALUE_SLOTS);
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      acc_en_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      acc_en_q <= (state_q == ST_RANK) && (wcnt_q != loc_word);
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    d_q    <= d_d;
    rem_q  <= rem_d;
    el_q   <= el_d;
    qc_q   <= qc_d;
    wcnt_q <= wcnt_d;
    rank_q <= rank_d;
    hit_q  <= hit_d;
    slot_q <= slot_d;
    use_q  <= use_d;
    oor_q  <= oor_d;
    if (out_load) begin
      out_value_q  <= (oor_q || !use_q) ? 32'd0 : val_rd_q;
      out_status_q <= oor_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && act == ACT_VALUE && 32'(value_slot_i) < VALUE_SLOTS) begin
      val_mem[SLOT_W'(value_slot_i)] <= packed_value_i;
    end
    if (state_q == ST_RD) begin
      val_rd_q <= val_mem[slot_q[SLOT_W-1:0]];
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = out_value_q;
  assign status_o    = out_status_q;

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result raised outside final step");

  a_rem_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RANK) |-> (CNT_W'(rem_q) < locs))
    else $error("location not below location count after divide");

  a_word_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RANK) |-> (wcnt_q <= loc_word))
    else $error("rank scan passed location word");

  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q) |-> (out_value_q == 32'd0))
    else $error("out-of-range result carries nonzero value");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && !out_load) |=> (state_q == ST_DONE))
    else $error("sequencer left final step without handing off result");

endmodule
